/* design/htf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htf_pkg
// Shared types, character codes and the hex digit helper of the telegram
// framer.
// ----------------------------------------------------------------------------
package htf_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [3:0] NIB_TEN  = 4'd10;
    localparam logic [6:0] XOR_CLEAR = 7'h00;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
    } htf_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_item;
        logic       end_of_frame;
    } htf_out_t;

    // one classified byte handed from the front to the back
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic [6:0] checksum;
    } htf_entry_t;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] res;
        if (nib < NIB_TEN) begin
            res = CH_ZERO + {3'b000, nib};
        end
        else begin
            res = CH_UPPER_A + {3'b000, nib} - {3'b000, NIB_TEN};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/htf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htf_front
// Accepts input bytes, keeps the running XOR of the open frame and pushes
// each byte with its frame checksum into the queue.
// ----------------------------------------------------------------------------
module htf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire htf_pkg::htf_in_t    byte_data,
    input  wire logic                queue_full,
    output logic                     push,
    output htf_pkg::htf_entry_t      push_data
);
    import htf_pkg::*;

    logic [6:0] running_xor_reg;
    logic [6:0] running_xor_next;
    logic [6:0] acc_base;
    logic [6:0] acc;

    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

    // a frame start restarts the sum at ':'
    assign acc_base = byte_data.first_byte ? CH_COLON : running_xor_reg;
    assign acc      = acc_base ^ hex_digit(byte_data.payload_byte[7:4])
                               ^ hex_digit(byte_data.payload_byte[3:0]);

    assign push_data.payload_byte = byte_data.payload_byte;
    assign push_data.first_byte   = byte_data.first_byte;
    assign push_data.last_byte    = byte_data.last_byte;
    assign push_data.checksum     = acc;

    always_comb
    begin
        running_xor_next = running_xor_reg;
        if (push) begin
            running_xor_next = byte_data.last_byte ? XOR_CLEAR : acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_xor_reg <= XOR_CLEAR;
        end
        else begin
            running_xor_reg <= running_xor_next;
        end
    end

endmodule
`default_nettype wire

/* design/htf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htf_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module htf_queue #(
    parameter int DEPTH = htf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire htf_pkg::htf_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output htf_pkg::htf_entry_t      head_data
);
    import htf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    htf_entry_t       slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

/* design/htf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htf_back
// Walks the head entry of the queue through its characters into the output
// register, one per cycle while char_stall does not hold a valid character.
// ----------------------------------------------------------------------------
module htf_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire htf_pkg::htf_entry_t head_data,
    output logic                     pop,
    output logic                     char_valid,
    input  wire logic                char_stall,
    output htf_pkg::htf_out_t        char_data
);
    import htf_pkg::*;

    typedef enum logic [2:0] {
        ST_START,
        ST_COLON,
        ST_HI,
        ST_LO,
        ST_CKH,
        ST_CKL,
        ST_CR,
        ST_LF
    } step_t;

    step_t      step_reg, step_next;
    step_t      cur_step;
    logic       out_valid_reg;
    htf_out_t   out_reg;
    logic       load;
    logic       is_final;
    logic [6:0] cur_char;

    assign load = head_valid && (!out_valid_reg || !char_stall);

    always_comb
    begin
        if (step_reg == ST_START) begin
            cur_step = head_data.first_byte ? ST_COLON : ST_HI;
        end
        else begin
            cur_step = step_reg;
        end
    end

    always_comb
    begin
        is_final  = 1'b0;
        cur_char  = CH_COLON;
        step_next = step_reg;
        unique case (cur_step)
            ST_COLON:
            begin
                cur_char  = CH_COLON;
                step_next = ST_HI;
            end
            ST_START, ST_HI:
            begin
                cur_char  = hex_digit(head_data.payload_byte[7:4]);
                step_next = ST_LO;
            end
            ST_LO:
            begin
                cur_char  = hex_digit(head_data.payload_byte[3:0]);
                is_final  = !head_data.last_byte;
                step_next = head_data.last_byte ? ST_CKH : ST_START;
            end
            ST_CKH:
            begin
                cur_char  = hex_digit({1'b0, head_data.checksum[6:4]});
                step_next = ST_CKL;
            end
            ST_CKL:
            begin
                cur_char  = hex_digit(head_data.checksum[3:0]);
                step_next = ST_CR;
            end
            ST_CR:
            begin
                cur_char  = CH_CR;
                step_next = ST_LF;
            end
            ST_LF:
            begin
                cur_char  = CH_LF;
                is_final  = 1'b1;
                step_next = ST_START;
            end
        endcase
    end

    // retire the entry with its last character
    assign pop = load && is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= ST_START;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else begin
            if (load) begin
                step_reg              <= step_next;
                out_valid_reg         <= 1'b1;
                out_reg.out_char      <= cur_char;
                out_reg.last_of_item  <= is_final;
                out_reg.end_of_frame  <= (cur_step == ST_LF);
            end
            else if (!char_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

    a_eof_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.end_of_frame) |->
            (out_reg.out_char == CH_LF && out_reg.last_of_item))
        else $error("end of frame on a character other than a closing LF");

    a_mid_entry_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != ST_START) |-> head_valid)
        else $error("sequencer mid entry without a queued entry");

    a_colon_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cur_char == CH_COLON && cur_step == ST_COLON) |->
            head_data.first_byte)
        else $error("colon emitted for a byte that opens no frame");

endmodule
`default_nettype wire

/* design/hex_ascii_telegram_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hex_ascii_telegram_framer
// Encodes a byte stream into ASCII hex telegrams with an XOR checksum.
//
// Input channel (byte_valid / byte_stall / byte_data): one byte per
// transaction with first_byte and last_byte marks. Output channel
// (char_valid / char_stall / char_data): one ASCII character per
// transaction, with last_of_item on the final character of a byte and
// end_of_frame on the closing LF.
// A byte makes 2 characters, 3 when it opens a frame, 6 when it closes one
// and 7 when it does both. The output register sends one character per
// cycle while char_stall is low. With the queue empty and the output free,
// a byte is written into a queue slot and its first character is then
// loaded into the output register.
// A queue of QUEUE_DEPTH bytes sits between input and output; byte_stall
// rises only while it is full.
// Reset clears the running checksum, the queue and the output register.
// While char_stall is high the output character holds; bytes keep being
// taken until the queue fills.
// ----------------------------------------------------------------------------
module hex_ascii_telegram_framer #(
    parameter int QUEUE_DEPTH = htf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire htf_pkg::htf_in_t  byte_data,
    output logic                   char_valid,
    input  wire logic              char_stall,
    output htf_pkg::htf_out_t      char_data
);
    import htf_pkg::*;

    logic       push;
    htf_entry_t push_data;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    htf_entry_t head_data;

    htf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    htf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    htf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule
`default_nettype wire
